### hw/rtl/gifd_pkg.sv
package gifd_pkg;

	localparam int unsigned InWidth   = 8;
	localparam int unsigned OutWidth  = 72;
	localparam int unsigned UserWidth = 4;

	typedef enum logic [2:0] {
		KIND_META    = 3'd0,
		KIND_RED     = 3'd1,
		KIND_GREEN   = 3'd2,
		KIND_BLUE    = 3'd3,
		KIND_LZW_MIN = 3'd4,
		KIND_LZW_DAT = 3'd5,
		KIND_IMG_END = 3'd6,
		KIND_TRAILER = 3'd7
	} gifd_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_SIGNATURE = 3'd1,
		ERR_EXT_LABEL = 3'd2,
		ERR_INTERLACE = 3'd3,
		ERR_INTRO     = 3'd4
	} gifd_err_t;

	typedef struct packed {
		logic       done_res;
		gifd_err_t  error_code;
		logic [15:0] screen_height;
		logic [15:0] screen_width;
		logic [15:0] frame_number;
		logic [7:0] table_index;
		logic       table_is_local;
		gifd_kind_t byte_kind;
		logic [7:0] data_byte;
	} gifd_res_t;

endpackage

### hw/rtl/gifd_parse.sv
module gifd_parse
	import gifd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] stream_byte,
	output gifd_res_t  res
);

	typedef enum logic [3:0] {
		PH_SIG, PH_LSD, PH_GCT, PH_BLOCK, PH_EXTLABEL, PH_EXTLEN, PH_EXTSKIP,
		PH_IMGDESC, PH_LCT, PH_LZWMIN, PH_DATALEN, PH_DATA, PH_DONE
	} phase_t;

	localparam logic [7:0] IntroExt     = 8'h21;
	localparam logic [7:0] IntroImage   = 8'h2c;
	localparam logic [7:0] IntroTrailer = 8'h3b;
	localparam logic [7:0] LabelGce     = 8'hf9;
	localparam logic [7:0] LabelPlain   = 8'h01;
	localparam logic [7:0] LabelComment = 8'hfe;
	localparam logic [7:0] LabelApp     = 8'hff;

	function automatic logic [7:0] sig_byte(input logic [2:0] pos);
		logic [7:0] b;
		unique case (pos)
			3'd0: b = 8'h47;
			3'd1: b = 8'h49;
			3'd2: b = 8'h46;
			3'd3: b = 8'h38;
			3'd4: b = 8'h39;
			3'd5: b = 8'h61;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	phase_t      phase_q, phase_d;
	logic [3:0]  pos_q, pos_d;
	logic [1:0]  comp_q, comp_d;
	logic [7:0]  idx_q, idx_d;
	logic [2:0]  size_q, size_d;
	logic [7:0]  sub_q, sub_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic        gtp_q, gtp_d;
	logic        ltp_q, ltp_d;
	logic [15:0] frame_q, frame_d;
	gifd_err_t   err_q, err_d;

	gifd_kind_t  kind;
	logic        local_sel;
	logic [7:0]  index;
	logic [7:0]  last_idx;
	logic [7:0]  sub_dec;

	assign last_idx = 8'((9'd2 << size_q) - 9'd1);
	assign sub_dec  = sub_q - 8'd1;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		comp_d    = 2'd0;
		idx_d     = 8'd0;
		size_d    = size_q;
		sub_d     = sub_q;
		width_d   = width_q;
		height_d  = height_q;
		gtp_d     = gtp_q;
		ltp_d     = ltp_q;
		frame_d   = frame_q;
		err_d     = err_q;
		kind      = KIND_META;
		local_sel = 1'b0;
		index     = 8'd0;
		unique case (phase_q)
			PH_SIG: begin
				if (pos_q > 4'd5 || stream_byte != sig_byte(pos_q[2:0])) begin
					err_d   = ERR_SIGNATURE;
					phase_d = PH_DONE;
				end else if (pos_q == 4'd5) begin
					pos_d   = 4'd0;
					phase_d = PH_LSD;
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_LSD: begin
				unique case (pos_q)
					4'd0: width_d[7:0]   = stream_byte;
					4'd1: width_d[15:8]  = stream_byte;
					4'd2: height_d[7:0]  = stream_byte;
					4'd3: height_d[15:8] = stream_byte;
					4'd4: begin
						gtp_d  = stream_byte[7];
						size_d = stream_byte[2:0];
					end
					default: ;
				endcase
				if (pos_q >= 4'd6) begin
					pos_d   = 4'd0;
					phase_d = gtp_q ? PH_GCT : PH_BLOCK;
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_GCT, PH_LCT: begin
				local_sel = (phase_q == PH_LCT);
				kind      = gifd_kind_t'(3'(comp_q) + 3'd1);
				index     = idx_q;
				// component and entry counters stand in for position mod/div 3
				if (comp_q == 2'd2) begin
					idx_d = idx_q + 8'd1;
					if (idx_q == last_idx) begin
						idx_d   = 8'd0;
						phase_d = (phase_q == PH_LCT) ? PH_LZWMIN : PH_BLOCK;
					end
				end else begin
					comp_d = comp_q + 2'd1;
					idx_d  = idx_q;
				end
			end
			PH_BLOCK: begin
				priority if (stream_byte == IntroTrailer) begin
					kind    = KIND_TRAILER;
					phase_d = PH_DONE;
				end else if (stream_byte == IntroExt) begin
					phase_d = PH_EXTLABEL;
				end else if (stream_byte == IntroImage) begin
					pos_d   = 4'd0;
					phase_d = PH_IMGDESC;
				end else begin
					err_d   = ERR_INTRO;
					phase_d = PH_DONE;
				end
			end
			PH_EXTLABEL: begin
				if (stream_byte == LabelGce || stream_byte == LabelPlain ||
				    stream_byte == LabelComment || stream_byte == LabelApp) begin
					phase_d = PH_EXTLEN;
				end else begin
					err_d   = ERR_EXT_LABEL;
					phase_d = PH_DONE;
				end
			end
			PH_EXTLEN: begin
				if (stream_byte == 8'd0) begin
					phase_d = PH_BLOCK;
				end else begin
					sub_d   = stream_byte;
					phase_d = PH_EXTSKIP;
				end
			end
			PH_EXTSKIP: begin
				sub_d = sub_dec;
				if (sub_dec == 8'd0) phase_d = PH_EXTLEN;
			end
			PH_IMGDESC: begin
				if (pos_q >= 4'd8) begin
					pos_d = 4'd0;
					if (stream_byte[6]) begin
						err_d   = ERR_INTERLACE;
						phase_d = PH_DONE;
					end else begin
						ltp_d   = stream_byte[7];
						size_d  = stream_byte[2:0];
						phase_d = stream_byte[7] ? PH_LCT : PH_LZWMIN;
					end
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_LZWMIN: begin
				kind      = KIND_LZW_MIN;
				local_sel = ltp_q;
				phase_d   = PH_DATALEN;
			end
			PH_DATALEN: begin
				if (stream_byte == 8'd0) begin
					kind      = KIND_IMG_END;
					local_sel = ltp_q;
					if (frame_q != 16'hffff) frame_d = frame_q + 16'd1;
					ltp_d   = 1'b0;
					phase_d = PH_BLOCK;
				end else begin
					sub_d   = stream_byte;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				kind      = KIND_LZW_DAT;
				local_sel = ltp_q;
				sub_d     = sub_dec;
				if (sub_dec == 8'd0) phase_d = PH_DATALEN;
			end
			default: phase_d = PH_DONE;
		endcase
	end

	always_comb begin
		res.data_byte      = stream_byte;
		res.byte_kind      = kind;
		res.table_is_local = local_sel;
		res.table_index    = index;
		res.frame_number   = frame_q;
		res.screen_width   = width_d;
		res.screen_height  = height_d;
		res.error_code     = err_d;
		res.done_res       = (phase_d == PH_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIG;
			pos_q    <= 4'd0;
			comp_q   <= 2'd0;
			idx_q    <= 8'd0;
			size_q   <= 3'd0;
			sub_q    <= 8'd0;
			width_q  <= 16'd0;
			height_q <= 16'd0;
			gtp_q    <= 1'b0;
			ltp_q    <= 1'b0;
			frame_q  <= 16'd0;
			err_q    <= ERR_NONE;
		end else if (step) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			comp_q   <= comp_d;
			idx_q    <= idx_d;
			size_q   <= size_d;
			sub_q    <= sub_d;
			width_q  <= width_d;
			height_q <= height_d;
			gtp_q    <= gtp_d;
			ltp_q    <= ltp_d;
			frame_q  <= frame_d;
			err_q    <= err_d;
		end
	end

endmodule

### hw/rtl/gif_block_deframer.sv
// GIF89a block deframer.
// s_* channel: one file byte per beat in s_tdata[7:0].
// m_* channel: one tagged beat per input byte, in order.
//   m_tuser: byte_kind[2:0], table_is_local[3].
//   m_tdata: data_byte[7:0], table_index[15:8], frame_number[31:16],
//            screen_width[47:32], screen_height[63:48], error_code[66:64],
//            done_res[67], zero pad [71:68].
// Pipeline: a byte taken goes into the input register, is parsed there,
// and its result is registered on m_* (two register stages).
// Throughput: one byte per cycle while m_tready is high; the parser state
// machine advances once per byte, its logic fitting between the two registers.
// Reset (arst_n low) returns the parser to the signature check, clears the
// captured screen size, frame count and error, and empties both stages.
// When m_tready is low the result register holds its beat and the input
// register still takes one more byte; s_tready drops once both are full.
// After the trailer or an error every byte is passed on as kind 0 with
// done_res set; errors stay until reset.
module gif_block_deframer
	import gifd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [InWidth-1:0]   s_tdata,  // stream_byte[7:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OutWidth-1:0]  m_tdata,  // see head comment for field map
	output logic [UserWidth-1:0] m_tuser   // byte_kind[2:0], table_is_local[3]
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       m_valid_q;
	gifd_res_t  res;
	gifd_res_t  res_q;
	logic       out_free;
	logic       adv;

	assign out_free = !m_valid_q || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (out_free) m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) byte_s1 <= s_tdata;
		if (adv) res_q <= res;
	end

	gifd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.stream_byte (byte_s1),
		.res         (res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tuser  = {res_q.table_is_local, res_q.byte_kind};
	assign m_tdata  = {4'd0, res_q.done_res, res_q.error_code, res_q.screen_height,
	                   res_q.screen_width, res_q.frame_number, res_q.table_index,
	                   res_q.data_byte};

endmodule

### hw/rtl/gifd_checker.sv
module gifd_checker
	import gifd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [InWidth-1:0]   s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [OutWidth-1:0]  m_tdata,
	input logic [UserWidth-1:0] m_tuser
);

	logic       done_seen_q;
	logic [2:0] err_seen_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = s_tvalid && s_tready && (s_tdata == s_tdata);
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_seen_q <= 1'b0;
			err_seen_q  <= ERR_NONE;
		end else if (out_beat) begin
			if (m_tdata[67]) done_seen_q <= 1'b1;
			if (m_tdata[66:64] != ERR_NONE) err_seen_q <= m_tdata[66:64];
		end
	end

	// an error always ends parsing
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[66:64] != ERR_NONE |-> m_tdata[67])
		else $error("error reported without done");

	// errors are sticky
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && err_seen_q != ERR_NONE |-> m_tdata[66:64] == err_seen_q && m_tdata[67])
		else $error("error code changed after it was raised");

	// nothing is tagged after the parse ended
	a_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && done_seen_q |-> m_tuser[2:0] == KIND_META && m_tdata[67])
		else $error("tagged beat after done");

	// table index only on color component beats
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !(m_tuser[2:0] == KIND_RED || m_tuser[2:0] == KIND_GREEN ||
		              m_tuser[2:0] == KIND_BLUE) |-> m_tdata[15:8] == 8'd0)
		else $error("table index on non-color beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && !in_beat |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output beat changed");

endmodule

bind gif_block_deframer gifd_checker u_gifd_checker (.*);

### verif/gif_block_deframer_tb.sv
module gif_block_deframer_tb;
	import gifd_pkg::*;

	localparam logic [47:0] MAGIC        = "GIF89a";
	localparam logic [7:0]  INTRO_EXT    = 8'h21;
	localparam logic [7:0]  INTRO_IMG    = 8'h2C;
	localparam logic [7:0]  INTRO_TRAIL  = 8'h3B;
	localparam logic [7:0]  LBL_GFX      = 8'hF9;
	localparam logic [7:0]  LBL_PLAIN    = 8'h01;
	localparam logic [7:0]  LBL_COMMENT  = 8'hFE;
	localparam logic [7:0]  LBL_APP      = 8'hFF;
	localparam int          RAND_TARGET  = 440;  // byte target; block 2, if it is an image, holds a 128-entry local table
	localparam int          CALM_TAIL    = 60;
	localparam int          HOLD_CYCLES  = 40;
	localparam int          STALL_LIMIT  = 2000;

	typedef enum logic [3:0] {
		ST_SIG, ST_LSD, ST_GCT, ST_BLOCK, ST_EXT_LABEL, ST_EXT_LEN, ST_EXT_SKIP,
		ST_IMG_DESC, ST_LCT, ST_LZW_MIN, ST_DATA_LEN, ST_DATA, ST_DONE
	} parse_st_t;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		gifd_res_t  r;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [InWidth-1:0]   s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OutWidth-1:0]  m_tdata;
	logic [UserWidth-1:0] m_tuser;

	gif_block_deframer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser state mirror
	parse_st_t   phase = ST_SIG;
	logic [9:0]  pos = '0;
	logic [8:0]  ct_size = '0;
	logic [7:0]  left = '0;
	logic [15:0] scr_w = '0;
	logic [15:0] scr_h = '0;
	logic        gct_on = 1'b0;
	logic        lct_on = 1'b0;
	logic [15:0] frames = '0;
	gifd_err_t   sticky_err = ERR_NONE;

	dir_row_t    dir_rows[$];
	logic [7:0]  file_bytes[$];
	gifd_res_t   pending_tags[$];
	int          n_in = 0;
	int          n_fail = 0;
	int          idle_cycles = 0;
	bit          calm = 1'b0;
	bit          hold_done = 1'b0;

	function automatic void halt(input gifd_err_t code);
		sticky_err = code;
		phase = ST_DONE;
	endfunction

	function automatic gifd_res_t tag_byte(input logic [7:0] b);
		gifd_res_t r;
		logic      is_lct;
		r = '0;
		r.data_byte = b;
		r.frame_number = frames;
		case (phase)
			ST_SIG: begin
				if (pos > 5 || b != MAGIC[47 - 8 * pos -: 8])
					halt(ERR_SIGNATURE);
				else if (pos == 5) begin
					pos = 0;
					phase = ST_LSD;
				end else
					pos++;
			end
			ST_LSD: begin
				case (pos)
					0: scr_w[7:0] = b;
					1: scr_w[15:8] = b;
					2: scr_h[7:0] = b;
					3: scr_h[15:8] = b;
					4: begin
						gct_on = b[7];
						ct_size = 9'(2 << b[2:0]);
					end
					default: ;
				endcase
				if (pos >= 6) begin
					pos = 0;
					phase = gct_on ? ST_GCT : ST_BLOCK;
				end else
					pos++;
			end
			ST_GCT, ST_LCT: begin
				is_lct = (phase == ST_LCT);
				r.table_is_local = is_lct;
				r.byte_kind = gifd_kind_t'(3'(1 + pos % 3));
				r.table_index = 8'(pos / 3);
				pos++;
				if (pos >= 3 * ct_size || pos > 767) begin
					pos = 0;
					phase = is_lct ? ST_LZW_MIN : ST_BLOCK;
				end
			end
			ST_BLOCK: begin
				if (b == INTRO_TRAIL) begin
					r.byte_kind = KIND_TRAILER;
					phase = ST_DONE;
				end else if (b == INTRO_EXT)
					phase = ST_EXT_LABEL;
				else if (b == INTRO_IMG) begin
					pos = 0;
					phase = ST_IMG_DESC;
				end else
					halt(ERR_INTRO);
			end
			ST_EXT_LABEL: begin
				if (b == LBL_GFX || b == LBL_PLAIN || b == LBL_COMMENT || b == LBL_APP)
					phase = ST_EXT_LEN;
				else
					halt(ERR_EXT_LABEL);
			end
			ST_EXT_LEN: begin
				if (b == 8'h00)
					phase = ST_BLOCK;
				else begin
					left = b;
					phase = ST_EXT_SKIP;
				end
			end
			ST_EXT_SKIP: begin
				left--;
				if (left == 0)
					phase = ST_EXT_LEN;
			end
			ST_IMG_DESC: begin
				if (pos >= 8) begin
					pos = 0;
					if (b[6])
						halt(ERR_INTERLACE);
					else begin
						lct_on = b[7];
						ct_size = 9'(2 << b[2:0]);
						phase = lct_on ? ST_LCT : ST_LZW_MIN;
					end
				end else
					pos++;
			end
			ST_LZW_MIN: begin
				r.byte_kind = KIND_LZW_MIN;
				r.table_is_local = lct_on;
				phase = ST_DATA_LEN;
			end
			ST_DATA_LEN: begin
				if (b == 8'h00) begin
					r.byte_kind = KIND_IMG_END;
					r.table_is_local = lct_on;
					if (frames != 16'hFFFF)
						frames++;
					lct_on = 1'b0;
					phase = ST_BLOCK;
				end else begin
					left = b;
					phase = ST_DATA;
				end
			end
			ST_DATA: begin
				r.byte_kind = KIND_LZW_DAT;
				r.table_is_local = lct_on;
				left--;
				if (left == 0)
					phase = ST_DATA_LEN;
			end
			default: phase = ST_DONE;
		endcase
		r.screen_width = scr_w;
		r.screen_height = scr_h;
		r.error_code = sticky_err;
		r.done_res = (phase == ST_DONE);
		return r;
	endfunction

	// expectation for the header rows, no error and frame 0 there
	function automatic gifd_res_t known_tag(input logic [7:0] b, input gifd_kind_t kind,
			input logic [7:0] idx, input logic [15:0] w, input logic [15:0] h);
		gifd_res_t r;
		r = '0;
		r.data_byte = b;
		r.byte_kind = kind;
		r.table_index = idx;
		r.screen_width = w;
		r.screen_height = h;
		r.error_code = ERR_NONE;
		return r;
	endfunction

	function automatic void add_row(input logic [7:0] b, input bit typed, input gifd_res_t r);
		dir_row_t row;
		row.b = b;
		row.typed = typed;
		row.r = r;
		dir_rows.push_back(row);
		file_bytes.push_back(b);
	endfunction

	function automatic void put(input logic [7:0] b);
		file_bytes.push_back(b);
	endfunction

	function automatic void put_subblocks(input int max_blocks, input int max_len);
		int nblk;
		int len;
		nblk = $urandom_range(0, max_blocks);
		for (int k = 0; k < nblk; k++) begin
			len = ($urandom_range(0, 59) == 0) ? 255 : $urandom_range(1, max_len);
			put(8'(len));
			repeat (len) put(8'($urandom_range(0, 255)));
		end
		put(8'h00);
	endfunction

	function automatic void put_ext();
		logic [7:0] labels[4];
		labels = '{LBL_GFX, LBL_PLAIN, LBL_COMMENT, LBL_APP};
		put(INTRO_EXT);
		put(labels[$urandom_range(0, 3)]);
		put_subblocks(3, 12);
	endfunction

	function automatic void put_image(input bit biggest);
		logic [7:0] packed_b;
		put(INTRO_IMG);
		repeat (8) put(8'($urandom_range(0, 255)));
		packed_b = 8'($urandom_range(0, 255)) & ~8'h40;
		if (biggest) begin
			packed_b[7] = 1'b1;
			packed_b[2:0] = 3'd6;
		end else if (packed_b[7])
			packed_b[2:0] = 3'($urandom_range(0, 2));
		put(packed_b);
		if (packed_b[7])
			repeat (3 * (2 << packed_b[2:0])) put(8'($urandom_range(0, 255)));
		put(8'($urandom_range(0, 255)));  // LZW min code size
		put_subblocks(3, 16);
	endfunction

	function automatic void build_file();
		int         blk;
		logic [7:0] b;
		// signature
		for (int k = 0; k < 6; k++)
			add_row(MAGIC[47 - 8 * k -: 8], 1'b1,
				known_tag(MAGIC[47 - 8 * k -: 8], KIND_META, 8'd0, 16'd0, 16'd0));
		// screen descriptor: width 0xFFFF, height 0x8001, 2-entry global table
		add_row(8'hFF, 1'b1, known_tag(8'hFF, KIND_META, 8'd0, 16'h00FF, 16'h0000));
		add_row(8'hFF, 1'b1, known_tag(8'hFF, KIND_META, 8'd0, 16'hFFFF, 16'h0000));
		add_row(8'h01, 1'b1, known_tag(8'h01, KIND_META, 8'd0, 16'hFFFF, 16'h0001));
		add_row(8'h80, 1'b1, known_tag(8'h80, KIND_META, 8'd0, 16'hFFFF, 16'h8001));
		add_row(8'h80, 1'b1, known_tag(8'h80, KIND_META, 8'd0, 16'hFFFF, 16'h8001));
		add_row(8'h00, 1'b1, known_tag(8'h00, KIND_META, 8'd0, 16'hFFFF, 16'h8001));
		add_row(8'hFF, 1'b1, known_tag(8'hFF, KIND_META, 8'd0, 16'hFFFF, 16'h8001));
		// global table
		add_row(8'h00, 1'b1, known_tag(8'h00, KIND_RED,   8'd0, 16'hFFFF, 16'h8001));
		add_row(8'hFF, 1'b1, known_tag(8'hFF, KIND_GREEN, 8'd0, 16'hFFFF, 16'h8001));
		add_row(8'h5A, 1'b1, known_tag(8'h5A, KIND_BLUE,  8'd0, 16'hFFFF, 16'h8001));
		add_row(8'hA5, 1'b1, known_tag(8'hA5, KIND_RED,   8'd1, 16'hFFFF, 16'h8001));
		add_row(8'h00, 1'b1, known_tag(8'h00, KIND_GREEN, 8'd1, 16'hFFFF, 16'h8001));
		add_row(8'hFF, 1'b1, known_tag(8'hFF, KIND_BLUE,  8'd1, 16'hFFFF, 16'h8001));
		// empty comment ext, then app ext whose payload looks like introducers
		add_row(INTRO_EXT, 1'b0, '0);
		add_row(LBL_COMMENT, 1'b0, '0);
		add_row(8'h00, 1'b0, '0);
		add_row(INTRO_EXT, 1'b0, '0);
		add_row(LBL_APP, 1'b0, '0);
		add_row(8'h02, 1'b0, '0);
		add_row(INTRO_TRAIL, 1'b0, '0);
		add_row(INTRO_IMG, 1'b0, '0);
		add_row(8'h00, 1'b0, '0);

		blk = 0;
		while (file_bytes.size() < dir_rows.size() + RAND_TARGET) begin
			if ($urandom_range(0, 9) < 4)
				put_ext();
			else
				put_image(blk == 2);
			blk++;
		end

		// file ends with the trailer or one of the fatal errors
		case ($urandom_range(0, 3))
			0: put(INTRO_TRAIL);
			1: begin
				put(INTRO_EXT);
				do b = 8'($urandom_range(0, 255));
				while (b == LBL_GFX || b == LBL_PLAIN || b == LBL_COMMENT || b == LBL_APP);
				put(b);
			end
			2: begin
				put(INTRO_IMG);
				repeat (8) put(8'($urandom_range(0, 255)));
				put(8'($urandom_range(0, 255)) | 8'h40);
			end
			default: begin
				do b = 8'($urandom_range(0, 255));
				while (b == INTRO_EXT || b == INTRO_IMG || b == INTRO_TRAIL);
				put(b);
			end
		endcase
		// garbage after done
		repeat (30) put(8'($urandom_range(0, 255)));
	endfunction

	task automatic report(input string what, input logic [15:0] want, input logic [15:0] seen);
		$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, seen);
		n_fail++;
	endtask

	// sender
	initial begin
		int pause_at;
		build_file();
		pause_at = dir_rows.size() + 400;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < file_bytes.size(); i++) begin
			if (i >= file_bytes.size() - CALM_TAIL)
				calm = 1'b1;
			if (i == pause_at) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_tags.size() != 0)
					@(posedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= file_bytes[i];
			do @(posedge clk);
			while (!s_tready);
		end
		s_tvalid <= 1'b0;
		while (pending_tags.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (n_fail == 0 && pending_tags.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// receiver
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && n_in >= 150) begin
				// long hold so both stages fill and s_tready drops
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				m_tready <= 1'b1;
			end else
				m_tready <= 1'b1;
		end
	end

	// predict on input beats, compare on output beats
	always @(posedge clk) begin
		gifd_res_t want;
		gifd_res_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = tag_byte(s_tdata);
				if (n_in < dir_rows.size() && dir_rows[n_in].typed)
					want = dir_rows[n_in].r;
				pending_tags.push_back(want);
				n_in++;
			end
			if (m_tvalid && m_tready) begin
				got.data_byte = m_tdata[7:0];
				got.table_index = m_tdata[15:8];
				got.frame_number = m_tdata[31:16];
				got.screen_width = m_tdata[47:32];
				got.screen_height = m_tdata[63:48];
				got.error_code = gifd_err_t'(m_tdata[66:64]);
				got.done_res = m_tdata[67];
				got.byte_kind = gifd_kind_t'(m_tuser[2:0]);
				got.table_is_local = m_tuser[3];
				if (pending_tags.size() == 0) begin
					$display("%0t: unexpected beat, expected none actual %h", $time, m_tdata);
					n_fail++;
				end else begin
					want = pending_tags.pop_front();
					if (got.data_byte !== want.data_byte)
						report("data_byte", 16'(want.data_byte), 16'(got.data_byte));
					if (got.byte_kind !== want.byte_kind)
						report("byte_kind", 16'(want.byte_kind), 16'(got.byte_kind));
					if (got.table_is_local !== want.table_is_local)
						report("table_is_local", 16'(want.table_is_local),
							16'(got.table_is_local));
					if (got.table_index !== want.table_index)
						report("table_index", 16'(want.table_index), 16'(got.table_index));
					if (got.frame_number !== want.frame_number)
						report("frame_number", want.frame_number, got.frame_number);
					if (got.screen_width !== want.screen_width)
						report("screen_width", want.screen_width, got.screen_width);
					if (got.screen_height !== want.screen_height)
						report("screen_height", want.screen_height, got.screen_height);
					if (got.error_code !== want.error_code)
						report("error_code", 16'(want.error_code), 16'(got.error_code));
					if (got.done_res !== want.done_res)
						report("done_res", 16'(want.done_res), 16'(got.done_res));
				end
			end
		end
	end

	// watchdog: no beat on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule

### gif_block_deframer.f
hw/rtl/gifd_pkg.sv
hw/rtl/gifd_parse.sv
hw/rtl/gif_block_deframer.sv
hw/rtl/gifd_checker.sv
verif/gif_block_deframer_tb.sv
